>>> design/iawo_pkg.sv
// Shared constants, types and helper functions of the IMU-aided wheel odometry block.
`default_nettype none
package iawo_pkg;

    localparam int CORDIC_STEPS = 20;
    localparam int CNT_W = $clog2(CORDIC_STEPS + 1);
    localparam int DW = 44;
    localparam int AW = 25;
    localparam int NW = 58;
    localparam int DENW = 25;

    localparam logic signed [AW-1:0] ANG_PI = 25'sd3294199;
    localparam logic signed [AW-1:0] ANG_HALF_PI = 25'sd1647099;
    localparam logic signed [AW-1:0] ANG_TWO_PI = 25'sd6588397;
    localparam logic signed [20:0] INV_GAIN = 21'sd636751;

    localparam logic [2:0] REG_LEFT_DPC = 3'd0;
    localparam logic [2:0] REG_RIGHT_DPC = 3'd1;
    localparam logic [2:0] REG_START_X = 3'd2;
    localparam logic [2:0] REG_START_Y = 3'd3;

    typedef struct packed {
        logic start;
        logic vect;
    } t_cordic_req;

    function automatic logic signed [AW-1:0] atan_at(input logic [4:0] i);
        logic signed [AW-1:0] r;
        case (i)
            5'd0: r = 25'sd823550;
            5'd1: r = 25'sd486170;
            5'd2: r = 25'sd256879;
            5'd3: r = 25'sd130396;
            5'd4: r = 25'sd65451;
            5'd5: r = 25'sd32757;
            5'd6: r = 25'sd16383;
            5'd7: r = 25'sd8192;
            5'd8: r = 25'sd4096;
            5'd9: r = 25'sd2048;
            5'd10: r = 25'sd1024;
            5'd11: r = 25'sd512;
            5'd12: r = 25'sd256;
            5'd13: r = 25'sd128;
            5'd14: r = 25'sd64;
            5'd15: r = 25'sd32;
            5'd16: r = 25'sd16;
            5'd17: r = 25'sd8;
            5'd18: r = 25'sd4;
            5'd19: r = 25'sd2;
            5'd20: r = 25'sd1;
            default: r = 25'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> design/iawo_cordic.sv
// Iterative CORDIC unit for vectoring (atan2) and rotation with gain correction.
`default_nettype none
module iawo_cordic
    import iawo_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cordic_req           i_req,
    input  wire logic signed [DW-1:0]  i_x,
    input  wire logic signed [DW-1:0]  i_y,
    input  wire logic signed [AW-1:0]  i_a,
    output logic                       o_done,
    output logic signed [DW-1:0]       o_x,
    output logic signed [DW-1:0]       o_y,
    output logic signed [AW-1:0]       o_z
);

    typedef enum logic [5:0] {
        C_IDLE = 6'b000001,
        C_RUN  = 6'b000010,
        C_GX   = 6'b000100,
        C_GY   = 6'b001000,
        C_GZ   = 6'b010000,
        C_DONE = 6'b100000
    } t_cstate;

    t_cstate r_state;
    logic r_vect;
    logic [CNT_W-1:0] r_i;
    logic signed [DW-1:0] r_x, r_y;
    logic signed [AW-1:0] r_z;
    logic signed [DW+20:0] r_p;

    logic signed [DW-1:0] n_x, n_y, xs, ys;
    logic signed [AW-1:0] n_z, a1, atv;
    logic sigma;
    logic signed [DW+20:0] rnd;

    assign xs = r_x >>> r_i;
    assign ys = r_y >>> r_i;
    assign atv = atan_at(5'(r_i));
    assign sigma = r_vect ? r_y[DW-1] : !r_z[AW-1];
    assign rnd = (r_p + (DW+21)'(524288)) >>> 20;

    always_comb begin
        n_x = i_x;
        n_y = i_y;
        n_z = '0;
        a1 = i_a;
        if (i_req.vect) begin
            if (i_x < 0) begin
                if (i_y >= 0) begin
                    n_x = i_y;
                    n_y = -i_x;
                    n_z = ANG_HALF_PI;
                end else begin
                    n_x = -i_y;
                    n_y = i_x;
                    n_z = -ANG_HALF_PI;
                end
            end
        end else begin
            if (i_a > ANG_PI) begin
                a1 = i_a - ANG_TWO_PI;
            end else if (i_a < -ANG_PI) begin
                a1 = i_a + ANG_TWO_PI;
            end
            n_z = a1;
            if (a1 > ANG_HALF_PI) begin
                n_x = -i_y;
                n_y = i_x;
                n_z = a1 - ANG_HALF_PI;
            end else if (a1 < -ANG_HALF_PI) begin
                n_x = i_y;
                n_y = -i_x;
                n_z = a1 + ANG_HALF_PI;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            case (r_state)
                C_IDLE: begin
                    if (i_req.start) begin
                        r_vect <= i_req.vect;
                        r_x <= n_x;
                        r_y <= n_y;
                        r_z <= n_z;
                        r_i <= '0;
                        if (i_req.vect && i_x == 0 && i_y == 0) begin
                            r_state <= C_DONE;
                        end else begin
                            r_state <= C_RUN;
                        end
                    end
                end
                C_RUN: begin
                    if (sigma) begin
                        r_x <= r_x - ys;
                        r_y <= r_y + xs;
                        r_z <= r_z - atv;
                    end else begin
                        r_x <= r_x + ys;
                        r_y <= r_y - xs;
                        r_z <= r_z + atv;
                    end
                    r_i <= r_i + 1'b1;
                    if (r_i == CNT_W'(CORDIC_STEPS - 1)) begin
                        r_state <= r_vect ? C_GZ : C_GX;
                    end
                end
                C_GX: begin
                    r_p <= r_x * INV_GAIN;
                    r_state <= C_GY;
                end
                C_GY: begin
                    r_x <= rnd[DW-1:0];
                    r_p <= r_y * INV_GAIN;
                    r_state <= C_GZ;
                end
                C_GZ: begin
                    if (r_vect) begin
                        if (r_z > ANG_PI) begin
                            r_z <= ANG_PI;
                        end else if (r_z < -ANG_PI) begin
                            r_z <= -ANG_PI;
                        end
                    end else begin
                        r_y <= rnd[DW-1:0];
                    end
                    r_state <= C_DONE;
                end
                C_DONE: begin
                    r_state <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_done = (r_state == C_DONE);
    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule
`default_nettype wire

>>> design/iawo_div.sv
// Bit-serial signed divider with truncation toward zero and 32-bit saturation.
`default_nettype none
module iawo_div
    import iawo_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic signed [NW-1:0]  i_num,
    input  wire logic [DENW-1:0]       i_den,
    output logic                       o_done,
    output logic signed [31:0]         o_q
);

    typedef enum logic [3:0] {
        D_IDLE = 4'b0001,
        D_RUN  = 4'b0010,
        D_FIN  = 4'b0100,
        D_DONE = 4'b1000
    } t_dstate;

    t_dstate r_state;
    logic [NW-1:0] r_n;
    logic [DENW-1:0] r_den, r_rem;
    logic r_neg;
    logic [$clog2(NW)-1:0] r_cnt;
    logic signed [31:0] r_q;

    logic [DENW:0] rem_sh, rem_sub;
    logic fits;

    assign rem_sh = {r_rem, r_n[NW-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign fits = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_n <= i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
                        r_neg <= i_num[NW-1];
                        r_den <= i_den;
                        r_rem <= '0;
                        r_cnt <= '0;
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    r_rem <= fits ? rem_sub[DENW-1:0] : rem_sh[DENW-1:0];
                    r_n <= {r_n[NW-2:0], fits};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == ($clog2(NW))'(NW - 1)) begin
                        r_state <= D_FIN;
                    end
                end
                D_FIN: begin
                    if (!r_neg) begin
                        r_q <= (r_n > NW'(64'd2147483647)) ? 32'sh7fffffff : r_n[31:0];
                    end else begin
                        r_q <= (r_n > NW'(64'd2147483648)) ? 32'sh80000000 : -r_n[31:0];
                    end
                    r_state <= D_DONE;
                end
                D_DONE: begin
                    r_state <= D_IDLE;
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_done = (r_state == D_DONE);
    assign o_q = r_q;

endmodule
`default_nettype wire

>>> design/imu_aided_wheel_odometry_unit.sv
// Top level of the IMU-aided wheel odometry block: sequencer, multiplier and state.
//
// Input requests arrive on the slave stream: tuser is the command (1 IMU
// orientation update, 0 encoder sample), tdata carries counts, interval and
// quaternion. An IMU request updates the heading and gives no result. An
// encoder request gives one result on the master stream with position,
// heading, speed and turn rate in tdata and the zero-interval flag in tuser.
// The block takes one request at a time. An IMU request passes through the
// idle state, the shared multiplier and a CORDIC vectoring run. An encoder
// request passes through the idle state, the multiplier, two CORDIC
// rotations, an accumulate step, two divisions in the bit-serial divider
// and an output step.
// A finished result waits in the output register while the next request is
// accepted; if the receiver stalls, the next result waits until it is taken.
// Configuration writes are accepted at any time and must only be made while
// the block is idle. Reset clears position, heading and the registers to
// their defaults and needs no clearing pass.
`default_nettype none
module imu_aided_wheel_odometry_unit
    import iawo_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    // left_ticks, right_ticks, time_step, quat_x, quat_y, quat_z, quat_w
    input  wire logic [135:0]  i_s_tdata,
    // command
    input  wire logic          i_s_tuser,
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    // pos_x, pos_y, heading, linear_speed, turn_rate, one zero pad bit
    output logic [151:0]       o_m_tdata,
    // zero_interval
    output logic               o_m_tuser,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [31:0]   i_cfg_data
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MUL  = 9'b000000010,
        S_VEC  = 9'b000000100,
        S_ROT1 = 9'b000001000,
        S_ROT2 = 9'b000010000,
        S_ACC  = 9'b000100000,
        S_DIVV = 9'b001000000,
        S_DIVW = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    t_state r_state;
    logic r_issued;
    logic [2:0] r_cnt;

    logic [31:0] r_ldpc, r_rdpc;
    logic signed [31:0] r_start_x, r_start_y, r_acc_x, r_acc_y;
    logic signed [22:0] r_yaw_now, r_yaw_before;

    logic r_cmd;
    logic signed [23:0] r_lc, r_rc;
    logic [23:0] r_dt;
    logic signed [15:0] r_qx, r_qy, r_qz, r_qw;

    logic signed [NW-1:0] r_prod, r_sa, r_sb;
    logic signed [31:0] r_v, r_w;

    logic r_ovalid;
    logic [151:0] r_odata;
    logic r_ouser;

    logic signed [24:0] op_a;
    logic signed [32:0] op_b;
    logic signed [23:0] dth;

    t_cordic_req c_req;
    logic signed [DW-1:0] c_xi, c_yi, c_xo, c_yo;
    logic signed [AW-1:0] c_ai, c_zo;
    logic c_done;

    logic d_start, d_done;
    logic signed [NW-1:0] d_num;
    logic [DENW-1:0] d_den;
    logic signed [31:0] d_q;

    logic zero_dt;
    logic signed [31:0] v_fin, w_fin, px, py;

    assign dth = 24'(r_yaw_now) - 24'(r_yaw_before);
    assign zero_dt = (r_dt == '0);

    always_comb begin
        op_a = '0;
        op_b = '0;
        case (r_cnt)
            3'd0: begin
                op_a = r_cmd ? 25'(r_qw) : 25'(r_lc);
                op_b = r_cmd ? 33'(r_qz) : $signed({1'b0, r_ldpc});
            end
            3'd1: begin
                op_a = r_cmd ? 25'(r_qx) : 25'(r_rc);
                op_b = r_cmd ? 33'(r_qy) : $signed({1'b0, r_rdpc});
            end
            3'd2: begin
                op_a = 25'(r_qy);
                op_b = 33'(r_qy);
            end
            3'd3: begin
                op_a = 25'(r_qz);
                op_b = 33'(r_qz);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_comb begin
        c_req.start = 1'b0;
        c_req.vect = 1'b0;
        c_xi = c_xo;
        c_yi = c_yo;
        c_ai = 25'(r_yaw_before);
        case (r_state)
            S_VEC: begin
                c_req.start = !r_issued;
                c_req.vect = 1'b1;
                c_xi = DW'(64'sd1073741824) - (DW'(r_sb) <<< 1);
                c_yi = DW'(r_sa) <<< 1;
            end
            S_ROT1: begin
                c_req.start = !r_issued;
                c_xi = DW'(r_sa >>> 17);
                c_yi = '0;
                c_ai = 25'(dth);
            end
            S_ROT2: begin
                c_req.start = !r_issued;
            end
            default: c_req.start = 1'b0;
        endcase
    end

    always_comb begin
        d_start = 1'b0;
        d_num = r_sa;
        d_den = {r_dt, 1'b0};
        case (r_state)
            S_DIVV: d_start = !r_issued;
            S_DIVW: begin
                d_start = !r_issued;
                d_num = NW'(dth) <<< 12;
                d_den = {1'b0, r_dt};
            end
            default: d_start = 1'b0;
        endcase
    end

    always_comb begin
        v_fin = r_v;
        w_fin = r_w;
        if (zero_dt) begin
            v_fin = (r_sa > 0) ? 32'sh7fffffff : ((r_sa < 0) ? 32'sh80000000 : 32'sd0);
            w_fin = (dth > 0) ? 32'sh7fffffff : ((dth < 0) ? 32'sh80000000 : 32'sd0);
        end
        px = sat32(64'(r_start_x) + 64'(r_acc_x));
        py = sat32(64'(r_start_y) + 64'(r_acc_y));
    end

    iawo_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (c_req),
        .i_x     (c_xi),
        .i_y     (c_yi),
        .i_a     (c_ai),
        .o_done  (c_done),
        .o_x     (c_xo),
        .o_y     (c_yo),
        .o_z     (c_zo)
    );

    iawo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (d_start),
        .i_num   (d_num),
        .i_den   (d_den),
        .o_done  (d_done),
        .o_q     (d_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ldpc <= 32'd267630;
            r_rdpc <= 32'd267630;
            r_start_x <= '0;
            r_start_y <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_LEFT_DPC: r_ldpc <= i_cfg_data;
                REG_RIGHT_DPC: r_rdpc <= i_cfg_data;
                REG_START_X: r_start_x <= i_cfg_data;
                REG_START_Y: r_start_y <= i_cfg_data;
                default: r_ldpc <= r_ldpc;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_issued <= 1'b0;
            r_cnt <= '0;
            r_acc_x <= '0;
            r_acc_y <= '0;
            r_yaw_now <= '0;
            r_yaw_before <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_m_tready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_cmd <= i_s_tuser;
                        r_lc <= i_s_tdata[23:0];
                        r_rc <= i_s_tdata[47:24];
                        r_dt <= i_s_tdata[71:48];
                        r_qx <= i_s_tdata[87:72];
                        r_qy <= i_s_tdata[103:88];
                        r_qz <= i_s_tdata[119:104];
                        r_qw <= i_s_tdata[135:120];
                        r_sa <= '0;
                        r_sb <= '0;
                        r_cnt <= '0;
                        r_issued <= 1'b0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod <= op_a * op_b;
                    if (r_cnt == 3'd1 || r_cnt == 3'd2) begin
                        r_sa <= r_sa + r_prod;
                    end
                    if (r_cnt == 3'd3 || r_cnt == 3'd4) begin
                        r_sb <= r_sb + r_prod;
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 3'd4) begin
                        r_state <= r_cmd ? S_VEC : S_ROT1;
                    end
                end
                S_VEC: begin
                    if (!r_issued) begin
                        r_issued <= 1'b1;
                    end else if (c_done) begin
                        r_issued <= 1'b0;
                        r_yaw_before <= r_yaw_now;
                        r_yaw_now <= c_zo[22:0];
                        r_state <= S_IDLE;
                    end
                end
                S_ROT1: begin
                    if (!r_issued) begin
                        r_issued <= 1'b1;
                    end else if (c_done) begin
                        r_issued <= 1'b0;
                        r_state <= S_ROT2;
                    end
                end
                S_ROT2: begin
                    if (!r_issued) begin
                        r_issued <= 1'b1;
                    end else if (c_done) begin
                        r_issued <= 1'b0;
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_acc_x <= sat32(64'(r_acc_x) + 64'(c_xo));
                    r_acc_y <= sat32(64'(r_acc_y) + 64'(c_yo));
                    r_state <= S_DIVV;
                end
                S_DIVV: begin
                    if (!r_issued) begin
                        r_issued <= 1'b1;
                    end else if (d_done) begin
                        r_issued <= 1'b0;
                        r_v <= d_q;
                        r_state <= S_DIVW;
                    end
                end
                S_DIVW: begin
                    if (!r_issued) begin
                        r_issued <= 1'b1;
                    end else if (d_done) begin
                        r_issued <= 1'b0;
                        r_w <= d_q;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata <= {1'b0, w_fin, v_fin, r_yaw_now, py, px};
                        r_ouser <= zero_dt;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata = r_odata;
    assign o_m_tuser = r_ouser;
    assign o_cfg_ready = 1'b1;

endmodule
`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench of the IMU-aided wheel odometry block with its own predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import iawo_pkg::*;

    typedef struct packed {
        logic        zero;
        logic [31:0] turn;
        logic [31:0] speed;
        logic [22:0] head;
        logic [31:0] py;
        logic [31:0] px;
    } t_odo;

    class odo_board;
        int errors;
        t_odo pending[$];
        logic [31:0] dpc_l, dpc_r;
        logic signed [31:0] org_x, org_y;
        logic signed [31:0] sum_x, sum_y;
        logic signed [22:0] yaw_cur, yaw_old;

        function void clear();
            dpc_l = 32'd267630;
            dpc_r = 32'd267630;
            org_x = 0;
            org_y = 0;
            sum_x = 0;
            sum_y = 0;
            yaw_cur = '0;
            yaw_old = '0;
            pending.delete();
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] d);
            case (idx)
                REG_LEFT_DPC: dpc_l = d;
                REG_RIGHT_DPC: dpc_r = d;
                REG_START_X: org_x = d;
                REG_START_Y: org_y = d;
                default: ;
            endcase
        endfunction

        function longint shr(longint v, int s);
            return v >>> s;
        endfunction

        function longint clip32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint atan_step(int i);
            longint tab[21] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383,
                8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};
            return (i < 21) ? tab[i] : 0;
        endfunction

        function longint vector_angle(longint x, longint y);
            longint z, t, xs, ys;
            z = 0;
            if (x == 0 && y == 0) return 0;
            if (x < 0) begin
                if (y >= 0) begin
                    t = x; x = y; y = -t; z = 1647099;
                end else begin
                    t = x; x = -y; y = t; z = -1647099;
                end
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                xs = shr(x, i);
                ys = shr(y, i);
                if (y >= 0) begin
                    x = x + ys; y = y - xs; z += atan_step(i);
                end else begin
                    x = x - ys; y = y + xs; z -= atan_step(i);
                end
            end
            if (z > 3294199) z = 3294199;
            if (z < -3294199) z = -3294199;
            return z;
        endfunction

        function void rotate(ref longint px, ref longint py, input longint a);
            longint x, y, t, xs, ys;
            x = px;
            y = py;
            if (a > 3294199) a -= 6588397;
            if (a < -3294199) a += 6588397;
            if (a > 1647099) begin
                t = x; x = -y; y = t; a -= 1647099;
            end else if (a < -1647099) begin
                t = x; x = y; y = -t; a += 1647099;
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                xs = shr(x, i);
                ys = shr(y, i);
                if (a >= 0) begin
                    x = x - ys; y = y + xs; a -= atan_step(i);
                end else begin
                    x = x + ys; y = y - xs; a += atan_step(i);
                end
            end
            px = shr(x * 636751 + (64'sd1 << 19), 20);
            py = shr(y * 636751 + (64'sd1 << 19), 20);
        endfunction

        function longint ratio(longint num, longint den, ref bit z);
            if (den == 0) begin
                z = 1;
                return num > 0 ? 64'sd2147483647 : (num < 0 ? -64'sd2147483648 : 0);
            end
            return clip32(num / den);
        endfunction

        function void note_request(logic cmd, logic [135:0] d);
            longint lc, rc, dt, s, dx, dy, dth, n, dn, v, w;
            longint qx, qy, qz, qw;
            bit z;
            t_odo r;
            if (cmd) begin
                qx = longint'($signed(d[87:72]));
                qy = longint'($signed(d[103:88]));
                qz = longint'($signed(d[119:104]));
                qw = longint'($signed(d[135:120]));
                n = 2 * (qw * qz + qx * qy);
                dn = (64'sd1 << 30) - 2 * (qy * qy + qz * qz);
                yaw_old = yaw_cur;
                yaw_cur = 23'(vector_angle(dn, n));
                return;
            end
            lc = longint'($signed(d[23:0]));
            rc = longint'($signed(d[47:24]));
            dt = longint'(d[71:48]);
            s = lc * longint'(dpc_l) + rc * longint'(dpc_r);
            dth = longint'(yaw_cur) - longint'(yaw_old);
            dx = shr(s, 17);
            dy = 0;
            rotate(dx, dy, dth);
            rotate(dx, dy, longint'(yaw_old));
            sum_x = 32'(clip32(longint'(sum_x) + dx));
            sum_y = 32'(clip32(longint'(sum_y) + dy));
            z = 0;
            v = ratio(s, 2 * dt, z);
            w = ratio(dth * 4096, dt, z);
            r.px = 32'(clip32(longint'(org_x) + longint'(sum_x)));
            r.py = 32'(clip32(longint'(org_y) + longint'(sum_y)));
            r.head = yaw_cur;
            r.speed = 32'(v);
            r.turn = 32'(w);
            r.zero = z;
            pending.push_back(r);
        endfunction

        function void check_result(logic [151:0] d, logic u);
            t_odo e;
            if (pending.size() == 0) begin
                $error("result with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[31:0] !== e.px) begin
                $error("pos_x exp %0h got %0h", e.px, d[31:0]); errors++;
            end
            if (d[63:32] !== e.py) begin
                $error("pos_y exp %0h got %0h", e.py, d[63:32]); errors++;
            end
            if (d[86:64] !== e.head) begin
                $error("heading exp %0h got %0h", e.head, d[86:64]); errors++;
            end
            if (d[118:87] !== e.speed) begin
                $error("linear_speed exp %0h got %0h", e.speed, d[118:87]); errors++;
            end
            if (d[150:119] !== e.turn) begin
                $error("turn_rate exp %0h got %0h", e.turn, d[150:119]); errors++;
            end
            if (u !== e.zero) begin
                $error("zero_interval exp %0b got %0b", e.zero, u); errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_s_tvalid = 0;
    logic [135:0] i_s_tdata = '0;
    logic i_s_tuser = 0;
    logic i_m_tready = 0;
    logic i_cfg_valid = 0;
    logic [2:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic o_s_tready, o_m_tvalid, o_m_tuser, o_cfg_ready;
    logic [151:0] o_m_tdata;

    odo_board board;
    bit hold_go = 0;
    bit hold_done = 0;
    int hold_cycles = 0;

    always #5 i_clk = ~i_clk;

    imu_aided_wheel_odometry_unit uut (.*);

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] d);
        @(negedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(idx, d);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic send_request(logic cmd, logic [135:0] d, bit gaps);
        int g;
        g = gaps ? pick_gap() : 0;
        if (g > 0) begin
            i_s_tvalid <= 0;
            repeat (g) @(negedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tuser <= cmd;
        i_s_tdata <= d;
        do @(posedge i_clk); while (!o_s_tready);
        board.note_request(cmd, d);
        @(negedge i_clk);
    endtask

    task automatic send_encoder(int lc, int rc, int dt, bit gaps);
        logic [135:0] d;
        d = '0;
        d[23:0] = 24'(lc);
        d[47:24] = 24'(rc);
        d[71:48] = 24'(dt);
        d[135:72] = {$urandom(), $urandom()};
        send_request(1'b0, d, gaps);
    endtask

    task automatic send_imu(int qx, int qy, int qz, int qw, bit gaps);
        logic [135:0] d;
        d = 136'({$urandom(), $urandom(), $urandom()});
        d[87:72] = 16'(qx);
        d[103:88] = 16'(qy);
        d[119:104] = 16'(qz);
        d[135:120] = 16'(qw);
        send_request(1'b1, d, gaps);
    endtask

    task automatic drain();
        i_s_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic random_phase(int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 35) begin
                send_imu($urandom, $urandom, $urandom, $urandom, 1);
            end else if (k < 70) begin
                send_encoder($signed($urandom_range(0, 4000)) - 2000,
                    $signed($urandom_range(0, 4000)) - 2000,
                    $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 20000), 1);
            end else begin
                send_encoder($urandom, $urandom, $urandom_range(0, 15) == 0 ? 0 : $urandom, 1);
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (hold_go && !hold_done) begin
            hold_done <= 1;
            hold_cycles <= 2000;
            i_m_tready <= 0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_m_tready <= 0;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) < 70) ||
                ($urandom_range(0, 99) < 50 && board != null && board.pending.size() > 1);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) board.check_result(o_m_tdata, o_m_tuser);
    end

    initial begin
        board = new();
        board.clear();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        send_encoder(0, 0, 0, 0);
        send_encoder(8388607, 8388607, 1, 0);
        send_encoder(-8388608, -8388608, 16777215, 0);
        send_encoder(-8388608, 8388607, 0, 0);
        send_imu(0, 0, 0, 0, 0);
        send_imu(0, 0, 32767, 0, 0);
        send_encoder(100, 100, 65536, 0);
        send_imu(0, 0, 32767, -32768, 0);
        send_encoder(-500, 300, 0, 0);
        send_imu(-32768, -32768, -32768, -32768, 0);
        send_imu(32767, 32767, 32767, 32767, 0);
        send_encoder(1000, 1000, 100, 0);
        send_imu(0, 0, -23170, 23170, 0);
        send_imu(0, 0, 23170, 23170, 0);
        send_encoder(7, -7, 5, 0);
        send_imu(0, 0, 0, 32767, 0);
        send_encoder(8388607, 8388607, 0, 0);
        drain();

        write_reg(REG_LEFT_DPC, 32'hffffffff);
        write_reg(REG_RIGHT_DPC, 32'hffffffff);
        write_reg(REG_START_X, 32'h7fffffff);
        write_reg(REG_START_Y, 32'h80000000);
        send_encoder(8388607, 8388607, 1, 0);
        send_encoder(-8388608, -8388608, 2, 0);
        random_phase(200);
        drain();

        write_reg(REG_LEFT_DPC, 32'h0);
        write_reg(REG_RIGHT_DPC, 32'h0);
        write_reg(REG_START_X, 32'h0);
        write_reg(REG_START_Y, 32'h0);
        random_phase(100);
        drain();

        write_reg(REG_LEFT_DPC, $urandom);
        write_reg(REG_RIGHT_DPC, $urandom);
        write_reg(REG_START_X, $urandom);
        write_reg(REG_START_Y, $urandom);
        @(negedge i_clk);
        hold_go = 1;
        random_phase(600);
        drain();

        write_reg(REG_LEFT_DPC, 32'd267630);
        write_reg(REG_RIGHT_DPC, 32'd300000);
        write_reg(REG_START_X, $urandom);
        write_reg(REG_START_Y, $urandom);
        random_phase(580);
        drain();

        if (board.errors == 0) begin
            $display("[imu_aided_wheel_odometry_unit] OK");
        end else begin
            $display("[imu_aided_wheel_odometry_unit] ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("[imu_aided_wheel_odometry_unit] ERROR");
        $finish;
    end
endmodule
`default_nettype wire

>>> filelist.f
design/iawo_pkg.sv
design/iawo_cordic.sv
design/iawo_div.sv
design/imu_aided_wheel_odometry_unit.sv
tb/tb.sv
